FILE: rtl/chained_hash_map_top_defines.svh
// Assertion macros for the hash map checker
`ifndef CHAINED_HASH_MAP_TOP_DEFINES_SVH
`define CHAINED_HASH_MAP_TOP_DEFINES_SVH
`define CHM_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CHM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: rtl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the chained hash map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package chm_pkg;
    localparam int MAX_BUCKETS = 64;
    localparam int POOL_NODES  = 256;
    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int NW = $clog2(POOL_NODES) + 1;
    localparam int IW = $clog2(POOL_NODES);
    localparam logic [NW-1:0] NIL_NODE = NW'(POOL_NODES);

    typedef enum logic [1:0] {OP_INSERT = 2'd0, OP_REMOVE = 2'd1,
                              OP_SEARCH = 2'd2, OP_OTHER = 2'd3} op_t;
    typedef enum logic [2:0] {ST_INSERTED = 3'd0, ST_UPDATED = 3'd1, ST_REMOVED = 3'd2,
                              ST_NOT_FOUND = 3'd3, ST_FOUND = 3'd4, ST_FULL = 3'd5} status_t;

    typedef enum logic [3:0] {S_IDLE, S_MOD, S_HEAD, S_HEADW, S_READ, S_READW,
                              S_CHECK, S_ACT, S_OUT} state_t;

    typedef struct packed {
        logic load;      // capture request
        logic mod_step;  // one restoring step of modulo
        logic head_rd;   // fetch bucket head
        logic node_rd;   // fetch current node
        logic advance;   // step along chain
        logic act;       // perform update
        logic out_load;  // load result
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic cur_nil;
        logic key_hit;
        logic walk_limit;
    } sts_t;
endpackage

FILE: rtl/chm_if.sv
// ----------------------------------------------------------------------------
// chm_req_if / chm_rsp_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface chm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
    modport source (output valid, operation, key, value, input ready);
    modport sink (input valid, operation, key, value, output ready);
endinterface

interface chm_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] found_value;
    modport source (output valid, status, found_value, input ready);
    modport sink (input valid, status, found_value, output ready);
endinterface

FILE: rtl/chained_hash_map_top.sv
// ----------------------------------------------------------------------------
// chained_hash_map_top
// Separate-chaining hash map over a 256-node pool.
// ----------------------------------------------------------------------------
// Flow: accept, serial modulo, bucket head read, chain walk, action, result load.
// One request at a time: the next is accepted once the last result is loaded for output.
// Stall: a result word held by the sink keeps the sequencer waiting and the input closed.
// Reset: async active low; bucket heads cleared via valid bits, pool and free list empty.
`timescale 1ns / 1ps
module chained_hash_map_top
    import chm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    chm_req_if.sink    req,
    chm_rsp_if.source  rsp
);
    cmd_t cmd;
    sts_t sts;
    logic out_busy;

    chm_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
                     .out_busy(out_busy), .sts(sts), .cmd(cmd));

    chm_datapath u_dp (.clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
                       .operation(req.operation), .key(req.key), .value(req.value),
                       .cmd(cmd), .sts(sts), .out_valid(rsp.valid), .out_ready(rsp.ready),
                       .out_busy(out_busy), .status(rsp.status),
                       .found_value(rsp.found_value));
endmodule

FILE: rtl/chm_ctrl.sv
// ----------------------------------------------------------------------------
// chm_ctrl
// Sequencer: modulo, chain walk, action and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chm_ctrl
    import chm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic out_busy,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_MOD;
            S_MOD:   if (sts.mod_done) state_next = S_HEAD;
            S_HEAD:  state_next = S_HEADW;
            S_HEADW: state_next = S_CHECK;
            S_CHECK:
            begin
                if (sts.cur_nil || sts.walk_limit)
                    state_next = S_ACT;
                else
                    state_next = S_READ;
            end
            S_READ:  state_next = S_READW;
            S_READW:
            begin
                if (sts.key_hit)
                    state_next = S_ACT;
                else
                    state_next = S_CHECK;
            end
            S_ACT:   state_next = S_OUT;
            S_OUT:   if (!out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:  begin in_ready = 1'b1; cmd.load = in_valid; end
            S_MOD:   cmd.mod_step = !sts.mod_done;
            S_HEAD:  cmd.head_rd = 1'b1;
            S_CHECK: cmd.node_rd = !(sts.cur_nil || sts.walk_limit);
            S_READW: cmd.advance = !sts.key_hit;
            S_ACT:   cmd.act = 1'b1;
            S_OUT:   cmd.out_load = !out_busy;
            default: cmd = '0;
        endcase
    end
endmodule

FILE: rtl/chm_datapath.sv
// ----------------------------------------------------------------------------
// chm_datapath
// Request registers, serial modulo, bucket table, node store, free list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chm_datapath
    import chm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic [1:0]         operation,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_busy,
    output logic [2:0]         status,
    output logic signed [31:0] found_value
);
    logic [6:0]  bcnt_reg;
    logic [1:0]  op_reg;
    logic [31:0] key_reg, val_reg, mag_reg;
    logic [6:0]  rem_reg;
    logic [5:0]  mcnt_reg;
    logic        mdone_reg;
    logic [6:0]  div_n;
    logic [7:0]  rtrial;
    logic [BW-1:0] bkt;

    logic [NW-1:0] bucket_head [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] head_vld_reg;
    logic [31:0]   node_key   [POOL_NODES];
    logic [31:0]   node_value [POOL_NODES];
    logic [NW-1:0] node_link  [POOL_NODES];

    logic [NW-1:0] head_rd_reg, cur_reg, prev_reg, free_reg, nk_link_reg, free_link_reg;
    logic [31:0]   nk_key_reg, nk_val_reg;
    logic [NW-1:0] used_reg;
    logic [NW-1:0] steps_reg;
    logic          cur_fresh_reg;
    logic [2:0]    st_reg;
    logic [31:0]   res_reg;
    logic          ov_reg;
    logic          nk_cur_ok, nk_ok_reg;

    always_comb
    begin
        if (bcnt_reg == 7'd0)
            div_n = 7'd1;
        else if (bcnt_reg > 7'(MAX_BUCKETS))
            div_n = 7'(MAX_BUCKETS);
        else
            div_n = bcnt_reg;
        rtrial = {rem_reg, mag_reg[31]};
    end
    assign bkt = rem_reg[BW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcnt_reg <= 7'd64;
        else if (cfg_we)
            bcnt_reg <= cfg_wdata;
    end

    // serial restoring modulo, one bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            key_reg  <= key;
            val_reg  <= value;
            mag_reg  <= key[31] ? (32'd0 - key) : key;
            rem_reg  <= '0;
            mcnt_reg <= '0;
            mdone_reg <= 1'b0;
        end
        else if (cmd.mod_step)
        begin
            mag_reg  <= {mag_reg[30:0], 1'b0};
            rem_reg  <= (rtrial >= {1'b0, div_n}) ? 7'(rtrial - {1'b0, div_n}) : rtrial[6:0];
            mcnt_reg <= mcnt_reg + 6'd1;
            mdone_reg <= (mcnt_reg == 6'd31);
        end
    end

    logic insert_new, have_free, have_fresh;
    logic [NW-1:0] new_node;
    assign have_free  = free_reg != NIL_NODE;
    assign have_fresh = used_reg < NW'(POOL_NODES);
    assign new_node   = have_free ? free_reg : used_reg;
    assign insert_new = (op_reg == OP_INSERT) && !sts.key_hit && (have_free || have_fresh);

    // walk state
    always_ff @(posedge clk)
    begin
        if (cmd.head_rd)
        begin
            head_rd_reg <= head_vld_reg[bkt] ? bucket_head[bkt] : NIL_NODE;
            free_link_reg <= node_link[free_reg[IW-1:0]];
        end
        if (cmd.node_rd)
        begin
            nk_key_reg  <= node_key[cur_reg[IW-1:0]];
            nk_val_reg  <= node_value[cur_reg[IW-1:0]];
            nk_link_reg <= node_link[cur_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= NIL_NODE; prev_reg <= NIL_NODE; steps_reg <= '0;
            cur_fresh_reg <= 1'b0;
        end
        else if (cmd.head_rd)
        begin
            cur_fresh_reg <= 1'b0; steps_reg <= '0; prev_reg <= NIL_NODE;
        end
        else if (!cur_fresh_reg && !cmd.node_rd && !cmd.advance && !cmd.act
                 && !cmd.out_load && !cmd.load && !cmd.mod_step)
        begin
            cur_reg <= head_rd_reg; cur_fresh_reg <= 1'b1;
        end
        else if (cmd.advance)
        begin
            prev_reg <= cur_reg; cur_reg <= nk_link_reg; steps_reg <= steps_reg + 1'b1;
        end
    end

    assign sts.mod_done   = mdone_reg;
    assign sts.cur_nil    = cur_reg == NIL_NODE;
    assign sts.key_hit    = nk_key_reg == key_reg && cur_reg != NIL_NODE && nk_cur_ok;
    assign sts.walk_limit = steps_reg == NW'(POOL_NODES);

    assign nk_cur_ok = nk_ok_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) nk_ok_reg <= 1'b0;
        else if (cmd.head_rd || cmd.advance) nk_ok_reg <= 1'b0;
        else if (cmd.node_rd) nk_ok_reg <= 1'b1;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.act)
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    if (sts.key_hit)
                        node_value[cur_reg[IW-1:0]] <= val_reg;
                    else if (have_free || have_fresh)
                    begin
                        node_key[new_node[IW-1:0]]   <= key_reg;
                        node_value[new_node[IW-1:0]] <= val_reg;
                        node_link[new_node[IW-1:0]]  <= head_rd_reg;
                        bucket_head[bkt] <= new_node;
                    end
                end
                OP_REMOVE:
                begin
                    if (sts.key_hit)
                    begin
                        if (prev_reg != NIL_NODE)
                            node_link[prev_reg[IW-1:0]] <= nk_link_reg;
                        else
                            bucket_head[bkt] <= nk_link_reg;
                        node_link[cur_reg[IW-1:0]] <= free_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= '0; free_reg <= NIL_NODE; used_reg <= '0;
        end
        else if (cmd.act)
        begin
            if (insert_new)
            begin
                head_vld_reg[bkt] <= 1'b1;
                if (have_free) free_reg <= free_link_reg;
                else used_reg <= used_reg + 1'b1;
            end
            else if (op_reg == OP_REMOVE && sts.key_hit)
            begin
                head_vld_reg[bkt] <= 1'b1;
                free_reg <= cur_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act)
        begin
            res_reg <= '0;
            case (op_reg)
                OP_INSERT: st_reg <= sts.key_hit ? ST_UPDATED
                                   : (have_free || have_fresh) ? ST_INSERTED : ST_FULL;
                OP_REMOVE: st_reg <= sts.key_hit ? ST_REMOVED : ST_NOT_FOUND;
                default:
                begin
                    st_reg  <= sts.key_hit ? ST_FOUND : ST_NOT_FOUND;
                    res_reg <= sts.key_hit ? nk_val_reg : 32'd0;
                end
            endcase
        end
    end

    logic [2:0]  ost_reg;
    logic [31:0] oval_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ov_reg <= 1'b0;
        else if (cmd.out_load) ov_reg <= 1'b1;
        else if (out_ready) ov_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ost_reg <= st_reg; oval_reg <= res_reg;
        end
    end
    assign out_valid   = ov_reg;
    assign out_busy    = ov_reg && !out_ready;
    assign status      = ost_reg;
    assign found_value = oval_reg;
endmodule

FILE: rtl/chm_checker.sv
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks of the hash map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chained_hash_map_top_defines.svh"
module chm_checker
    import chm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] status,
    input logic [31:0] found_value
);
    `CHM_ASSERT_IMPL(a_status_range, clk, rst_n, rsp_valid, status <= ST_FULL)
    `CHM_ASSERT_IMPL(a_value_zero, clk, rst_n, rsp_valid && status != ST_FOUND, found_value == 32'd0)
    `CHM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)
    `CHM_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status))
endmodule

bind chained_hash_map_top chm_checker u_chk (.clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready), .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready), .status(rsp.status), .found_value(rsp.found_value));
